>>> hdl/ldfi_pkg.sv
// Package of the loop detector frame inductance unit: frame layout constants,
// register codes and reset values, controller/datapath structs, hex decoding.
// Depends on nothing; the CSR interface, controller, datapath, top level and checker use it.
`default_nettype none

package ldfi_pkg;

   localparam int FRAME_LENGTH_DEF = 56;
   localparam int LOOP_COUNT_DEF   = 4;
   localparam int MAX_LOOPS        = 4;
   localparam int FIRST_DIGIT      = 5;
   localparam int DIGITS_PER_CHANNEL = 12;
   localparam int DIV_STEPS        = 32;

   localparam logic [7:0] START_MARK = 8'h3C;
   localparam logic [7:0] END_MARK   = 8'h3E;

   localparam logic [3:0] D_CLK_FIRST = 4'd0;
   localparam logic [3:0] D_CLK_LAST  = 4'd7;
   localparam logic [3:0] D_PER_FIRST = 4'd8;
   localparam logic [3:0] D_PER_LAST  = 4'd11;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE   = 2'd2;

   localparam logic [23:0] SCALE_RESET  = 24'd6467101;
   localparam logic [19:0] OFFSET_RESET = 20'd150000;
   localparam logic [2:0]  LANE_RESET   = 3'd0;

   localparam logic [23:0] ROUND_HALF = 24'h800000;
   localparam logic [31:0] SAT_MAX    = 32'h7FFFFFFF;

   typedef struct packed {
      logic       accept;
      logic       div_step;
      logic       square;
      logic       mul_lo;
      logic       mul_hi;
      logic       sum;
      logic       write;
      logic       emit;
      logic [1:0] emit_idx;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic start_calc;
      logic frame_good;
      logic out_free;
   } status_type;

   function automatic logic [3:0] digit_value(input logic [7:0] b);
      logic [7:0] v;
      v = 8'd0;
      if (b inside {[8'h30:8'h39]}) begin
         v = b - 8'h30;
      end else if (b inside {[8'h41:8'h46]}) begin
         v = b - 8'h37;
      end else if (b inside {[8'h61:8'h66]}) begin
         v = b - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/ldfi_req_if.sv
// Request channel of the loop detector frame inductance unit: one received byte.
// Depends on nothing.
`default_nettype none

interface ldfi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
   modport monitor (input valid, input rx_byte, input ready);
endinterface

`default_nettype wire

>>> hdl/ldfi_rsp_if.sv
// Result channel of the loop detector frame inductance unit: one channel value.
// Depends on nothing.
`default_nettype none

interface ldfi_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         lane_tag;
   logic [1:0]         channel_index;
   logic signed [31:0] inductance_nh;
   logic               no_period_count;
   logic               last_channel;

   modport source (output valid, output lane_tag, output channel_index,
                   output inductance_nh, output no_period_count,
                   output last_channel, input ready);
   modport sink (input valid, input lane_tag, input channel_index,
                 input inductance_nh, input no_period_count,
                 input last_channel, output ready);
   modport monitor (input valid, input lane_tag, input channel_index,
                    input inductance_nh, input no_period_count,
                    input last_channel, input ready);
endinterface

`default_nettype wire

>>> hdl/ldfi_csr_if.sv
// Configuration write channel of the loop detector frame inductance unit.
// Depends on ldfi_pkg for the index and data widths.
`default_nettype none

interface ldfi_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ldfi_pkg::CSR_IDX_W-1:0]   index;
   logic [ldfi_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
   modport monitor (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

>>> hdl/ldfi_ctrl.sv
// Controller of the loop detector frame inductance unit: sequences byte
// acceptance, the divide/square/scale steps and result emission.
// Depends on ldfi_pkg and ldfi_req_if.
`default_nettype none

module ldfi_ctrl #(
   parameter int LOOP_COUNT = ldfi_pkg::LOOP_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ldfi_req_if.sink                  req_ch,
   input  wire ldfi_pkg::status_type st,
   output ldfi_pkg::cmd_type         cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_MLO  = 3'd3;
   localparam logic [2:0] S_MHI  = 3'd4;
   localparam logic [2:0] S_SUM  = 3'd5;
   localparam logic [2:0] S_WR   = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   localparam logic [4:0] DIV_LAST  = 5'(ldfi_pkg::DIV_STEPS - 1);
   localparam logic [1:0] EMIT_LAST = 2'(LOOP_COUNT - 1);

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] em_ff, em_in;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      em_in    = em_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd.accept = 1'b1;
               if (st.start_calc) begin
                  state_in = S_DIV;
                  cnt_in   = 5'd0;
               end else if (st.frame_good) begin
                  state_in = S_EMIT;
                  em_in    = 2'd0;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.square = 1'b1;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.write = 1'b1;
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_idx  = em_ff;
               cmd.emit_last = (em_ff == EMIT_LAST);
               em_in = em_ff + 2'd1;
               if (em_ff == EMIT_LAST) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
         em_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         em_ff    <= em_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ldfi_dp.sv
// Datapath of the loop detector frame inductance unit: frame parser, hex
// accumulator, restoring divider, squarer, shared scale multiplier, result
// store, output register and configuration registers. Depends on ldfi_pkg
// and the ldfi_rsp_if and ldfi_csr_if interfaces.
`default_nettype none

module ldfi_dp #(
   parameter int FRAME_LENGTH = ldfi_pkg::FRAME_LENGTH_DEF,
   parameter int LOOP_COUNT   = ldfi_pkg::LOOP_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ldfi_pkg::cmd_type cmd,
   output ldfi_pkg::status_type   st,
   input  wire logic [7:0]        rx_byte,
   ldfi_rsp_if.source             rsp_ch,
   ldfi_csr_if.sink               csr_ch
);

   localparam logic [5:0] LAST_POS  = 6'(FRAME_LENGTH - 1);
   localparam logic [5:0] DIG_BEGIN = 6'(ldfi_pkg::FIRST_DIGIT);
   localparam logic [5:0] DIG_END   =
      6'(ldfi_pkg::FIRST_DIGIT + ldfi_pkg::DIGITS_PER_CHANNEL * LOOP_COUNT);

   logic [23:0] scale_ff;
   logic [19:0] offset_ff;
   logic [2:0]  lane_ff;

   logic        in_frame_ff, in_frame_in;
   logic [5:0]  pos_ff, pos_in;
   logic [3:0]  dig_ff, dig_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] hold_ff, hold_in;

   logic [15:0] per_ff;
   logic [1:0]  wr_ch_ff;
   logic [15:0] rem_ff;
   logic [31:0] quo_ff;
   logic [63:0] q2_ff;
   logic [55:0] a_ff;
   logic [55:0] b_ff;
   logic [40:0] v_ff;
   logic        sat_ff;

   logic [31:0] res_ff [ldfi_pkg::MAX_LOOPS];
   logic        zf_ff  [ldfi_pkg::MAX_LOOPS];

   logic        rsp_valid_ff;
   logic [2:0]  rsp_lane_ff;
   logic [1:0]  rsp_idx_ff;
   logic [31:0] rsp_val_ff;
   logic        rsp_zf_ff;
   logic        rsp_last_ff;

   logic        in_digits;
   logic        at_last;
   logic [3:0]  dv;
   logic [31:0] acc_new;
   logic [17:0] trial;
   logic        ge;
   logic [31:0] mul_op;
   logic [55:0] prod;
   logic [40:0] limit;
   logic [40:0] diff;

   assign in_digits = (pos_ff >= DIG_BEGIN) && (pos_ff < DIG_END);
   assign at_last   = (pos_ff >= LAST_POS);
   assign dv        = ldfi_pkg::digit_value(rx_byte);
   assign acc_new   = ((dig_ff == ldfi_pkg::D_CLK_FIRST) || (dig_ff == ldfi_pkg::D_PER_FIRST))
                      ? {28'd0, dv} : {acc_ff[27:0], dv};

   assign st.start_calc = in_frame_ff && in_digits && (dig_ff == ldfi_pkg::D_PER_LAST);
   assign st.frame_good = in_frame_ff && at_last && (rx_byte == ldfi_pkg::END_MARK);
   assign st.out_free   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      dig_in      = dig_ff;
      chan_in     = chan_ff;
      acc_in      = acc_ff;
      hold_in     = hold_ff;
      if (cmd.accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == ldfi_pkg::START_MARK) begin
               in_frame_in = 1'b1;
               pos_in      = 6'd1;
               dig_in      = 4'd0;
               chan_in     = 2'd0;
            end
         end else begin
            if (in_digits) begin
               acc_in = acc_new;
               if (dig_ff == ldfi_pkg::D_CLK_LAST) begin
                  hold_in = acc_new;
               end
               if (dig_ff == ldfi_pkg::D_PER_LAST) begin
                  dig_in  = 4'd0;
                  chan_in = chan_ff + 2'd1;
               end else begin
                  dig_in = dig_ff + 4'd1;
               end
            end
            if (at_last) begin
               in_frame_in = 1'b0;
               pos_in      = 6'd0;
               acc_in      = 32'd0;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= 6'd0;
         dig_ff      <= 4'd0;
         chan_ff     <= 2'd0;
         acc_ff      <= 32'd0;
         hold_ff     <= 32'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         dig_ff      <= dig_in;
         chan_ff     <= chan_in;
         acc_ff      <= acc_in;
         hold_ff     <= hold_in;
      end
   end

   assign trial  = {1'b0, rem_ff, quo_ff[31]} - {2'b00, per_ff};
   assign ge     = !trial[17];
   assign mul_op = cmd.mul_hi ? q2_ff[63:32] : q2_ff[31:0];
   assign prod   = {32'd0, scale_ff} * {24'd0, mul_op};
   assign limit  = {9'd0, ldfi_pkg::SAT_MAX} + {21'd0, offset_ff};
   assign diff   = v_ff - {21'd0, offset_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept && st.start_calc) begin
         per_ff   <= acc_new[15:0];
         wr_ch_ff <= chan_ff;
         quo_ff   <= hold_ff;
         rem_ff   <= 16'd0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? trial[15:0] : {rem_ff[14:0], quo_ff[31]};
         quo_ff <= {quo_ff[30:0], ge};
      end
      if (cmd.square) begin
         q2_ff <= {32'd0, quo_ff} * {32'd0, quo_ff};
      end
      if (cmd.mul_lo) begin
         a_ff <= prod + {32'd0, ldfi_pkg::ROUND_HALF};
      end
      if (cmd.mul_hi) begin
         b_ff <= prod;
      end
      if (cmd.sum) begin
         v_ff   <= {9'd0, a_ff[55:24]} + {1'b0, b_ff[31:0], 8'd0};
         sat_ff <= |b_ff[55:32];
      end
      if (cmd.write) begin
         if (per_ff == 16'd0) begin
            res_ff[wr_ch_ff] <= 32'd0;
            zf_ff[wr_ch_ff]  <= 1'b1;
         end else begin
            zf_ff[wr_ch_ff] <= 1'b0;
            if (sat_ff || (v_ff > limit)) begin
               res_ff[wr_ch_ff] <= ldfi_pkg::SAT_MAX;
            end else begin
               res_ff[wr_ch_ff] <= diff[31:0];
            end
         end
      end
      if (cmd.emit) begin
         rsp_lane_ff <= lane_ff;
         rsp_idx_ff  <= cmd.emit_idx;
         rsp_val_ff  <= res_ff[cmd.emit_idx];
         rsp_zf_ff   <= zf_ff[cmd.emit_idx];
         rsp_last_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.lane_tag        = rsp_lane_ff;
   assign rsp_ch.channel_index   = rsp_idx_ff;
   assign rsp_ch.inductance_nh   = rsp_val_ff;
   assign rsp_ch.no_period_count = rsp_zf_ff;
   assign rsp_ch.last_channel    = rsp_last_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= ldfi_pkg::SCALE_RESET;
         offset_ff <= ldfi_pkg::OFFSET_RESET;
         lane_ff   <= ldfi_pkg::LANE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ldfi_pkg::CSR_SCALE: begin
               scale_ff <= csr_ch.data[23:0];
            end
            ldfi_pkg::CSR_OFFSET: begin
               offset_ff <= csr_ch.data[19:0];
            end
            ldfi_pkg::CSR_LANE: begin
               lane_ff <= csr_ch.data[2:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hdl/loop_detector_frame_inductance_unit.sv
// A byte request is taken while the controller is idle; the byte that completes a
// channel's period count holds the input through the restoring divider, square,
// two scale partial products, sum and store write.
// A good end mark releases the frame's channel results one per cycle, when
// the output register is free; no byte is taken until the last one is loaded.
// Reset (synchronous) restores default registers and hunts for a start mark.
`default_nettype none

module loop_detector_frame_inductance_unit #(
   parameter int FRAME_LENGTH = ldfi_pkg::FRAME_LENGTH_DEF,
   parameter int LOOP_COUNT   = ldfi_pkg::LOOP_COUNT_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ldfi_req_if.sink   req_ch,
   ldfi_rsp_if.source rsp_ch,
   ldfi_csr_if.sink   csr_ch
);

   ldfi_pkg::cmd_type    cmd;
   ldfi_pkg::status_type st;

   ldfi_ctrl #(
      .LOOP_COUNT(LOOP_COUNT)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .st    (st),
      .cmd   (cmd)
   );

   ldfi_dp #(
      .FRAME_LENGTH(FRAME_LENGTH),
      .LOOP_COUNT  (LOOP_COUNT)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .st     (st),
      .rx_byte(req_ch.rx_byte),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

`default_nettype wire

>>> hdl/ldfi_checker.sv
// Port-level checks of the loop detector frame inductance unit, with the bind
// that attaches them to the top level. Depends on ldfi_pkg.
`default_nettype none

module ldfi_checker #(
   parameter int LOOP_COUNT = ldfi_pkg::LOOP_COUNT_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_channel_index,
   input wire logic [31:0] rsp_inductance_nh,
   input wire logic        rsp_last_channel
);

   localparam logic [1:0] EMIT_LAST = 2'(LOOP_COUNT - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_inductance_nh) && $stable(rsp_channel_index)))
      else $error("Stalled result request changed.");

   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_channel) |=>
         (rsp_valid && (rsp_channel_index == 2'($past(rsp_channel_index) + 2'd1))))
      else $error("Channel results of a frame are not consecutive.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_channel) |-> (rsp_channel_index == EMIT_LAST))
      else $error("Last channel flag on the wrong channel.");

   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_channel) |-> !req_ready)
      else $error("Byte request taken while a frame is still being emitted.");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind loop_detector_frame_inductance_unit ldfi_checker #(
   .LOOP_COUNT(LOOP_COUNT)
) u_ldfi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_channel_index(rsp_ch.channel_index),
   .rsp_inductance_nh(rsp_ch.inductance_nh),
   .rsp_last_channel (rsp_ch.last_channel)
);

`default_nettype wire
